// ----- design/isrt_pkg.sv -----
// ----------------------------------------------------------------------------
// isrt_pkg: shared types and codes for the index set range translator
// Beat layouts of the request and result channels, request and status codes,
// and the default table depth.
// ----------------------------------------------------------------------------
package isrt_pkg;

  localparam int unsigned MAX_RANGES_DEF = 1024;

  // Request codes carried in req_type.
  localparam logic [1:0] REQ_BUILD  = 2'd0;
  localparam logic [1:0] REQ_GLOBAL = 2'd1;
  localparam logic [1:0] REQ_LOCAL  = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_ORDER   = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic [30:0] SPACE_SIZE_RESET = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [1:0]          req_type;
    logic signed [31:0]  index_value;
    logic                last_of_build;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0]  mapped_value;
    logic [1:0]          status;
    logic [10:0]         range_count;
  } out_item_t;

endpackage

// ----- design/index_set_range_translator.sv -----
// ----------------------------------------------------------------------------
// index_set_range_translator: interval set with rank lookup
// Packs an ascending build stream into a table of contiguous ranges and
// translates between global indices and local positions by binary search.
// ----------------------------------------------------------------------------
// The block handles one beat at a time and holds in_stall high until that
// beat's result has been loaded into the output register; a result waiting on
// out_stall does not stop the next request being taken in the cycle after. A
// build beat goes from S_BUILD to S_EMIT, passing through S_CLOSE when it
// closes the build (the closing range is written through the one table write
// port in a step of its own). A query runs a binary search over the ranges
// held: each halving step is a registered read of the range tables followed
// by one pass through the shared key comparator, and one more read fetches the
// chosen range for the final check. Queries made while a build is open, queries
// that fail the range check, and unknown request codes go from S_QCHK straight
// to S_EMIT.
module index_set_range_translator #(
  parameter int unsigned MAX_RANGES = isrt_pkg::MAX_RANGES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  isrt_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output isrt_pkg::out_item_t  out_item,
  input  logic                 cfg_wr_en,
  input  logic [30:0]          cfg_wr_data
);

  localparam int unsigned AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int unsigned CW = $clog2(MAX_RANGES + 1);
  localparam logic [CW:0] MAX_C = (CW + 1)'(MAX_RANGES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BUILD,
    S_CLOSE,
    S_QCHK,
    S_RD,
    S_CMP,
    S_FIX,
    S_EMIT
  } state_t;

  state_t              state_r, state_nxt;
  logic [1:0]          req_r, req_nxt;
  logic [31:0]         v_r, v_nxt;
  logic                last_r, last_nxt;
  logic [30:0]         iss_r, iss_nxt;
  logic [CW-1:0]       held_r, held_nxt;
  logic [31:0]         total_r, total_nxt;
  logic [30:0]         prev_r, prev_nxt;
  logic [30:0]         ostart_r, ostart_nxt;
  logic                open_r, open_nxt;
  logic [CW-1:0]       lo_r, lo_nxt;
  logic [CW-1:0]       hi_r, hi_nxt;
  logic [31:0]         res_mapped_r, res_mapped_nxt;
  logic [1:0]          res_status_r, res_status_nxt;
  logic                out_valid_r, out_valid_nxt;
  isrt_pkg::out_item_t out_r, out_nxt;

  // Range tables, one entry per completed range.
  logic [30:0] start_mem  [MAX_RANGES];
  logic [31:0] stop_mem   [MAX_RANGES];
  logic [31:0] offset_mem [MAX_RANGES];
  logic [30:0] st_rd_r;
  logic [31:0] sp_rd_r;
  logic [31:0] of_rd_r;

  logic          wr_en;
  logic [AW-1:0] rd_addr;

  // Close path: shared by gap steps and the end of a build.
  logic          do_close;
  logic [31:0]   cl_stop;
  logic [31:0]   cl_len;
  logic          cl_room;

  logic [30:0]   u;
  logic [CW-1:0] mid;
  logic [CW-1:0] lo_m1;
  logic [AW-1:0] bsel;
  logic [31:0]   key;
  logic [31:0]   held_w;
  logic          q_ok;
  logic          open_after;
  logic [1:0]    bstat;

  assign cl_stop = {1'b0, prev_r} + 32'd1;
  assign cl_len  = cl_stop - {1'b0, ostart_r};
  assign cl_room = ({1'b0, held_r} < MAX_C);

  assign u      = v_r[30:0];
  assign mid    = lo_r + ((hi_r - lo_r) >> 1);
  assign lo_m1  = lo_r - CW'(1);
  assign bsel   = (lo_r == '0) ? '0 : lo_m1[AW-1:0];
  assign key    = (req_r == isrt_pkg::REQ_GLOBAL) ? {1'b0, st_rd_r} : of_rd_r;
  assign held_w = 32'(held_r);

  always_comb begin
    if (req_r == isrt_pkg::REQ_GLOBAL) begin
      q_ok = !open_r && !v_r[31] && (u < iss_r) && (held_r != '0);
    end else if (req_r == isrt_pkg::REQ_LOCAL) begin
      q_ok = !open_r && !v_r[31] && (v_r < total_r) && (held_r != '0);
    end else begin
      q_ok = 1'b0;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    v_nxt          = v_r;
    last_nxt       = last_r;
    iss_nxt        = cfg_wr_en ? cfg_wr_data : iss_r;
    held_nxt       = held_r;
    total_nxt      = total_r;
    prev_nxt       = prev_r;
    ostart_nxt     = ostart_r;
    open_nxt       = open_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    res_mapped_nxt = res_mapped_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_nxt        = out_r;
    do_close       = 1'b0;
    rd_addr        = '0;
    open_after     = open_r;
    bstat          = isrt_pkg::ST_INVALID;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_item.req_type;
          v_nxt     = in_item.index_value;
          last_nxt  = in_item.last_of_build;
          state_nxt = (in_item.req_type == isrt_pkg::REQ_BUILD) ? S_BUILD : S_QCHK;
        end
      end
      S_BUILD: begin
        if (v_r[31]) begin
          bstat = isrt_pkg::ST_ORDER;
        end else if (!open_r) begin
          // First index of a build: the old table is discarded.
          held_nxt   = '0;
          total_nxt  = '0;
          ostart_nxt = u;
          prev_nxt   = u;
          open_after = 1'b1;
        end else if ((u == prev_r) || ({1'b0, u} == cl_stop)) begin
          prev_nxt = u;
        end else if (u < prev_r) begin
          bstat = isrt_pkg::ST_ORDER;
        end else if (({1'b0, held_r} + 1'b1) >= MAX_C) begin
          bstat = isrt_pkg::ST_FULL;
        end else begin
          do_close   = 1'b1;
          ostart_nxt = u;
          prev_nxt   = u;
        end
        open_nxt       = open_after;
        res_mapped_nxt = '1;
        res_status_nxt = bstat;
        state_nxt      = (last_r && open_after) ? S_CLOSE : S_EMIT;
      end
      S_CLOSE: begin
        do_close = cl_room;
        open_nxt = 1'b0;
        if (res_status_r == isrt_pkg::ST_INVALID) begin
          res_status_nxt = isrt_pkg::ST_OK;
        end
        state_nxt = S_EMIT;
      end
      S_QCHK: begin
        lo_nxt         = '0;
        hi_nxt         = held_r;
        res_mapped_nxt = '1;
        res_status_nxt = isrt_pkg::ST_INVALID;
        state_nxt      = q_ok ? S_RD : S_EMIT;
      end
      S_RD: begin
        if (lo_r < hi_r) begin
          rd_addr   = mid[AW-1:0];
          state_nxt = S_CMP;
        end else begin
          // Search done: fetch the last range whose key is not above the index, or range 0.
          rd_addr   = bsel;
          state_nxt = S_FIX;
        end
      end
      S_CMP: begin
        if (key <= v_r) begin
          lo_nxt = mid + CW'(1);
        end else begin
          hi_nxt = mid;
        end
        state_nxt = S_RD;
      end
      S_FIX: begin
        if (req_r == isrt_pkg::REQ_GLOBAL) begin
          if ((v_r >= {1'b0, st_rd_r}) && (v_r < sp_rd_r)) begin
            res_mapped_nxt = v_r - {1'b0, st_rd_r} + of_rd_r;
            res_status_nxt = isrt_pkg::ST_OK;
          end
        end else begin
          res_mapped_nxt = v_r - of_rd_r + {1'b0, st_rd_r};
          res_status_nxt = isrt_pkg::ST_OK;
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt.mapped_value = res_mapped_r;
          out_nxt.status       = res_status_r;
          out_nxt.range_count  = held_w[10:0];
          out_valid_nxt        = 1'b1;
          state_nxt            = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (do_close) begin
      held_nxt  = held_r + CW'(1);
      total_nxt = total_r + cl_len;
    end
  end

  assign wr_en = do_close;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      start_mem[held_r[AW-1:0]]  <= ostart_r;
      stop_mem[held_r[AW-1:0]]   <= cl_stop;
      offset_mem[held_r[AW-1:0]] <= total_r;
    end
    st_rd_r <= start_mem[rd_addr];
    sp_rd_r <= stop_mem[rd_addr];
    of_rd_r <= offset_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      iss_r       <= isrt_pkg::SPACE_SIZE_RESET;
      held_r      <= '0;
      total_r     <= '0;
      prev_r      <= '0;
      ostart_r    <= '0;
      open_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iss_r       <= iss_nxt;
      held_r      <= held_nxt;
      total_r     <= total_nxt;
      prev_r      <= prev_nxt;
      ostart_r    <= ostart_nxt;
      open_r      <= open_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r        <= req_nxt;
    v_r          <= v_nxt;
    last_r       <= last_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    res_mapped_r <= res_mapped_nxt;
    res_status_r <= res_status_nxt;
    out_r        <= out_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // The table count never passes its depth.
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, held_r} <= MAX_C))
    else $error("range count beyond table depth");

  // A search step only compares while the window is non-empty.
  a_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (lo_r < hi_r))
    else $error("compare with empty search window");

  // Closing a build adds one range and leaves no build open.
  a_close: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLOSE && cl_room) |=> (held_r == $past(held_r) + CW'(1)) && !open_r)
    else $error("build close did not record a range");

  // A query made while a build is open goes straight to its result.
  a_open_query: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_QCHK && open_r) |=>
      (state_r == S_EMIT && res_status_r == isrt_pkg::ST_INVALID))
    else $error("query searched during an open build");

  // A new result beat only appears straight after the emit step.
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("result beat raised outside emit step");

endmodule

// ----- tb/tb_index_set_range_translator.sv -----
// ----------------------------------------------------------------------------
// tb_index_set_range_translator: self-checking bench for the range translator
// Streams build and query beats through the block under randomised valid and
// stall gaps, predicts every result with an internal range table and compares
// each result beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_index_set_range_translator;

  localparam int unsigned TABLE_DEPTH = isrt_pkg::MAX_RANGES_DEF;
  localparam logic [1:0]  REQ_UNUSED  = 2'd3;
  localparam longint      INDEX_TOP   = 2147483647;
  localparam int          QUIET_LIMIT = 3000;
  localparam int          LONG_HOLD   = 150;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  isrt_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  isrt_pkg::out_item_t out_item;
  logic                cfg_wr_en = 1'b0;
  logic [30:0]         cfg_wr_data = '0;

  always #10 clk = ~clk;

  index_set_range_translator i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Predicted state of the range table.
  logic [30:0] seg_first [TABLE_DEPTH];
  logic [31:0] seg_end   [TABLE_DEPTH];
  logic [31:0] seg_rank  [TABLE_DEPTH];
  int unsigned segs_held = 0;
  logic [31:0] rank_total = '0;
  logic [30:0] last_idx = '0;
  logic [30:0] run_first = '0;
  bit          run_open = 1'b0;
  logic [30:0] space_limit = isrt_pkg::SPACE_SIZE_RESET;

  isrt_pkg::in_item_t  pending_beats [$];
  isrt_pkg::out_item_t expected_results [$];
  int          beats_queued = 0;
  int          beats_taken = 0;
  int          mismatch_count = 0;
  int          results_seen = 0;
  bit          in_taken = 1'b0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_left = 0;
  int          holds_done = 0;
  int          quiet_cycles = 0;
  int unsigned chunks_run = 0;
  longint      gen_lo = 0;
  longint      gen_prev = 0;
  longint      gen_count = 0;

  function automatic void close_run();
    if (segs_held < TABLE_DEPTH) begin
      seg_first[segs_held] = run_first;
      seg_end[segs_held]   = 32'(longint'(last_idx) + 1);
      seg_rank[segs_held]  = rank_total;
      rank_total = rank_total + 32'(longint'(last_idx) + 1 - longint'(run_first));
      segs_held++;
    end
  endfunction

  function automatic logic [1:0] add_to_build(longint v, bit last);
    logic [1:0] st;
    if (v < 0) begin
      st = isrt_pkg::ST_ORDER;
    end else if (!run_open) begin
      // A fresh build throws the old table away.
      segs_held  = 0;
      rank_total = '0;
      run_first  = v[30:0];
      last_idx   = v[30:0];
      run_open   = 1'b1;
      st         = isrt_pkg::ST_INVALID;
    end else if (v == longint'(last_idx) || v == longint'(last_idx) + 1) begin
      last_idx = v[30:0];
      st       = isrt_pkg::ST_INVALID;
    end else if (v < longint'(last_idx)) begin
      st = isrt_pkg::ST_ORDER;
    end else if (segs_held + 1 >= TABLE_DEPTH) begin
      st = isrt_pkg::ST_FULL;
    end else begin
      close_run();
      run_first = v[30:0];
      last_idx  = v[30:0];
      st        = isrt_pkg::ST_INVALID;
    end
    if (last && run_open) begin
      close_run();
      run_open = 1'b0;
      if (st == isrt_pkg::ST_INVALID) st = isrt_pkg::ST_OK;
    end
    return st;
  endfunction

  // Last slot whose key does not exceed v, or slot 0.
  function automatic int unsigned seg_below(bit by_rank, longint v);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    longint      key;
    lo = 0;
    hi = segs_held;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      key = by_rank ? longint'(seg_rank[mid]) : longint'(seg_first[mid]);
      if (key <= v) lo = mid + 1;
      else hi = mid;
    end
    return (lo == 0) ? 0 : lo - 1;
  endfunction

  function automatic isrt_pkg::out_item_t translate_beat(isrt_pkg::in_item_t it);
    isrt_pkg::out_item_t r;
    longint              v;
    longint              m;
    int unsigned         b;
    v = longint'($signed(it.index_value));
    m = -1;
    r = '0;
    r.status = isrt_pkg::ST_INVALID;
    case (it.req_type)
      isrt_pkg::REQ_BUILD: begin
        r.status = add_to_build(v, it.last_of_build);
      end
      isrt_pkg::REQ_GLOBAL: begin
        if (!run_open && v >= 0 && v < longint'(space_limit) && segs_held > 0) begin
          b = seg_below(1'b0, v);
          if (v >= longint'(seg_first[b]) && v < longint'(seg_end[b])) begin
            m = v - longint'(seg_first[b]) + longint'(seg_rank[b]);
            r.status = isrt_pkg::ST_OK;
          end
        end
      end
      isrt_pkg::REQ_LOCAL: begin
        if (!run_open && v >= 0 && v < longint'(rank_total) && segs_held > 0) begin
          b = seg_below(1'b1, v);
          m = longint'(seg_first[b]) + v - longint'(seg_rank[b]);
          r.status = isrt_pkg::ST_OK;
        end
      end
      default: ;
    endcase
    r.mapped_value = m[31:0];
    r.range_count  = 11'(segs_held);
    return r;
  endfunction

  function automatic void queue_beat(logic [1:0] req, longint v, bit last);
    isrt_pkg::in_item_t b;
    b.req_type      = req;
    b.index_value   = v[31:0];
    b.last_of_build = last;
    pending_beats = {pending_beats, b};
    beats_queued++;
  endfunction

  function automatic logic [30:0] pick_space(int unsigned nth);
    if (nth == 0) return '0;
    if (nth == 1) return isrt_pkg::SPACE_SIZE_RESET;
    case ($urandom_range(5))
      0: return isrt_pkg::SPACE_SIZE_RESET;
      1: return 31'd1;
      2, 3: return 31'($urandom_range(0, 400));
      default: return 31'($urandom);
    endcase
  endfunction

  // Input driver: a new beat is offered only once the previous one has gone.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_item  <= pending_beats.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver stall, with two long hold-offs that back the block up.
  always @(negedge clk) begin
    if (hold_left == 0 && holds_done < 2 && beats_taken >= (holds_done == 0 ? 40 : 900)) begin
      hold_left = LONG_HOLD;
      holds_done++;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Prediction on accepted requests and checking of accepted results.
  always @(posedge clk) begin
    isrt_pkg::out_item_t want;
    isrt_pkg::out_item_t pred;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        pred = translate_beat(in_item);
        expected_results = {expected_results, pred};
        beats_taken++;
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result beat %0d with nothing expected: mapped %0d status %0d",
                     results_seen, out_item.mapped_value, out_item.status,
                     " ranges %0d", out_item.range_count);
        end else begin
          want = expected_results.pop_front();
          if (out_item.mapped_value !== want.mapped_value
              || out_item.status !== want.status
              || out_item.range_count !== want.range_count) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("result beat %0d: expected mapped %0d status %0d ranges %0d,",
                       results_seen, want.mapped_value, want.status, want.range_count,
                       " got %0d %0d %0d",
                       out_item.mapped_value, out_item.status, out_item.range_count);
          end
        end
      end
    end
  end

  // Watchdog: ends the run when no beat has moved on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles", quiet_cycles);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic wait_drained();
    while (pending_beats.size() != 0 || beats_taken != beats_queued
           || expected_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic set_space(logic [30:0] val);
    @(negedge clk);
    cfg_wr_data <= val;
    cfg_wr_en   <= 1'b1;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    space_limit = val;
  endtask

  task automatic gen_build_run(int len, bit close_it);
    longint idx;
    longint step;
    int     pick;
    bit     last;
    case ($urandom_range(3))
      0, 1: idx = $urandom_range(0, 200);
      2: idx = $urandom_range(0, 32'h7FFF_FFFF);
      default: idx = 32'h7FFF_FFFF - $urandom_range(0, 300);
    endcase
    gen_lo = idx;
    gen_count = 1;
    queue_beat(isrt_pkg::REQ_BUILD, idx, close_it && len == 1);
    for (int k = 1; k < len; k++) begin
      last = close_it && (k == len - 1);
      pick = $urandom_range(99);
      if (pick < 4) begin
        queue_beat(isrt_pkg::REQ_BUILD, -longint'($urandom_range(1, 32'h8000_0000)), last);
      end else if (pick < 9) begin
        queue_beat(isrt_pkg::REQ_BUILD, idx - longint'($urandom_range(1, 40)), last);
      end else if (pick < 12 && !last) begin
        queue_beat($urandom_range(1) ? isrt_pkg::REQ_GLOBAL : isrt_pkg::REQ_LOCAL, idx,
                   1'($urandom_range(1)));
      end else begin
        if (pick < 27) step = 0;
        else if (pick < 70) step = 1;
        else if (pick < 93) step = $urandom_range(2, 20);
        else step = $urandom_range(21, 1000000);
        if (idx + step > INDEX_TOP) step = 0;
        idx += step;
        if (step != 0) gen_count++;
        queue_beat(isrt_pkg::REQ_BUILD, idx, last);
      end
    end
    gen_prev = idx;
  endtask

  // Fills the table to the last slot, then offers further gap steps that
  // must be refused, the final one closing the build.
  task automatic gen_full_table();
    longint idx;
    queue_beat(isrt_pkg::REQ_BUILD, 0, 1'b1);
    idx = $urandom_range(0, 1000);
    gen_lo = idx;
    gen_count = 1;
    queue_beat(isrt_pkg::REQ_BUILD, idx, 1'b0);
    for (int k = 0; k < TABLE_DEPTH + 2; k++) begin
      if ($urandom_range(19) == 0) begin
        idx++;
        gen_count++;
        queue_beat(isrt_pkg::REQ_BUILD, idx, 1'b0);
      end
      idx += $urandom_range(2, 6);
      gen_count++;
      queue_beat(isrt_pkg::REQ_BUILD, idx, k == TABLE_DEPTH + 1);
    end
    gen_prev = idx;
  endtask

  task automatic gen_queries(int n);
    longint span;
    int     pick;
    span = gen_prev - gen_lo;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 45)
        queue_beat(isrt_pkg::REQ_GLOBAL,
                   gen_lo - 2 + longint'($urandom_range(0, 32'(span + 4))),
                   1'($urandom_range(1)));
      else if (pick < 85)
        queue_beat(isrt_pkg::REQ_LOCAL,
                   longint'($urandom_range(0, 32'(gen_count + 1))) - 1,
                   1'($urandom_range(1)));
      else if (pick < 95)
        queue_beat($urandom_range(1) ? isrt_pkg::REQ_GLOBAL : isrt_pkg::REQ_LOCAL,
                   longint'($urandom), 1'($urandom_range(1)));
      else
        queue_beat(REQ_UNUSED, longint'($urandom), 1'($urandom_range(1)));
    end
  endtask

  // Each chunk starts from an idle block with a fresh space size.
  task automatic run_chunks(int budget);
    int first;
    int runs;
    first = beats_queued;
    while (beats_queued - first < budget) begin
      wait_drained();
      set_space(pick_space(chunks_run));
      chunks_run++;
      runs = $urandom_range(1, 3);
      repeat (runs)
        gen_build_run(($urandom_range(6) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 25),
                      $urandom_range(9) != 0);
      gen_queries($urandom_range(8, 24));
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 20;
    recv_idle_pct = 45;

    // Empty table, unknown request and a negative index with no build open.
    queue_beat(isrt_pkg::REQ_GLOBAL, 5, 1'b0);
    queue_beat(isrt_pkg::REQ_LOCAL, 0, 1'b0);
    queue_beat(REQ_UNUSED, 0, 1'b0);
    queue_beat(isrt_pkg::REQ_BUILD, -1, 1'b1);
    // A build with repeats, unit steps, gaps, descending and negative
    // indices, up to the top of the index space.
    queue_beat(isrt_pkg::REQ_BUILD, 0, 1'b0);
    queue_beat(isrt_pkg::REQ_GLOBAL, 0, 1'b0);
    queue_beat(isrt_pkg::REQ_BUILD, 0, 1'b0);
    queue_beat(isrt_pkg::REQ_BUILD, 1, 1'b0);
    queue_beat(isrt_pkg::REQ_BUILD, 5, 1'b0);
    queue_beat(isrt_pkg::REQ_BUILD, 3, 1'b0);
    queue_beat(isrt_pkg::REQ_BUILD, -longint'(32'h8000_0000), 1'b0);
    queue_beat(isrt_pkg::REQ_BUILD, 6, 1'b0);
    queue_beat(isrt_pkg::REQ_BUILD, INDEX_TOP - 1, 1'b0);
    queue_beat(isrt_pkg::REQ_BUILD, INDEX_TOP, 1'b1);
    queue_beat(isrt_pkg::REQ_GLOBAL, 0, 1'b1);
    queue_beat(isrt_pkg::REQ_GLOBAL, 2, 1'b0);
    queue_beat(isrt_pkg::REQ_GLOBAL, 6, 1'b0);
    queue_beat(isrt_pkg::REQ_GLOBAL, INDEX_TOP - 1, 1'b0);
    queue_beat(isrt_pkg::REQ_GLOBAL, INDEX_TOP, 1'b0);
    queue_beat(isrt_pkg::REQ_GLOBAL, -1, 1'b0);
    queue_beat(isrt_pkg::REQ_LOCAL, 5, 1'b0);
    queue_beat(isrt_pkg::REQ_LOCAL, 6, 1'b0);
    queue_beat(isrt_pkg::REQ_LOCAL, -longint'(32'h8000_0000), 1'b0);
    // A descending index that still closes the build, then a one-index build.
    queue_beat(isrt_pkg::REQ_BUILD, 10, 1'b0);
    queue_beat(isrt_pkg::REQ_BUILD, 9, 1'b1);
    queue_beat(isrt_pkg::REQ_BUILD, 7, 1'b1);
    queue_beat(isrt_pkg::REQ_LOCAL, 0, 1'b0);

    run_chunks(40);

    wait_drained();
    send_idle_pct = 45;
    recv_idle_pct = 20;
    set_space(isrt_pkg::SPACE_SIZE_RESET);
    gen_full_table();
    gen_queries(40);
    run_chunks(20);

    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_chunks(40);

    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
